// File: rtl/core/srst_pkg.sv
// Shared constants and register indexes for the solar relay sleep timer.
// No dependencies; every other file imports this package.
`default_nettype none

package srst_pkg;

    // Default widths of the tick counters and of the converter samples.
    localparam int COUNT_BITS_DEF  = 20;
    localparam int SAMPLE_BITS_DEF = 10;

    // Configuration bus geometry: eight 32-bit registers at byte addresses 4*i.
    localparam int REG_COUNT     = 8;
    localparam int REG_IDX_BITS  = 3;
    localparam int APB_ADDR_BITS = REG_IDX_BITS + 2;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_MEASURE_INTERVAL = 3'd0,
        REG_RELAY_HOLD       = 3'd1,
        REG_LONG_ACTIVE      = 3'd2,
        REG_SHORT_ACTIVE     = 3'd3,
        REG_SLEEP            = 3'd4,
        REG_RELAY_ON_CODE    = 3'd5,
        REG_LONG_WIN_CODE    = 3'd6,
        REG_SHORT_WIN_CODE   = 3'd7
    } reg_idx_t;

    // Reset values. Voltage thresholds are raw converter codes:
    // volts = code * 5 / 1024 * 7100 / 2000, rounded down to the code.
    localparam int RST_MEASURE_INTERVAL = 1000;
    localparam int RST_RELAY_HOLD       = 530000;
    localparam int RST_LONG_ACTIVE      = 530000;
    localparam int RST_SHORT_ACTIVE     = 6000;
    localparam int RST_SLEEP            = 530000;
    localparam int RST_RELAY_ON_CODE    = 634;   // about 11 V
    localparam int RST_LONG_WIN_CODE    = 346;   // about 6 V
    localparam int RST_SHORT_WIN_CODE   = 289;   // about 5 V

endpackage

`default_nettype wire

// File: rtl/core/srst_cfg.sv
// APB-style configuration register file for the solar relay sleep timer.
// Depends on srst_pkg for register indexes, reset values and bus widths.
`default_nettype none

module srst_cfg
    import srst_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    output logic      [COUNT_BITS-1:0]    measure_interval,
    output logic      [COUNT_BITS-1:0]    relay_hold,
    output logic      [COUNT_BITS-1:0]    long_active,
    output logic      [COUNT_BITS-1:0]    short_active,
    output logic      [COUNT_BITS-1:0]    sleep_len,
    output logic      [SAMPLE_BITS-1:0]   relay_on_code,
    output logic      [SAMPLE_BITS-1:0]   long_win_code,
    output logic      [SAMPLE_BITS-1:0]   short_win_code
);

    logic [COUNT_BITS-1:0]  measure_interval_reg;
    logic [COUNT_BITS-1:0]  relay_hold_reg;
    logic [COUNT_BITS-1:0]  long_active_reg;
    logic [COUNT_BITS-1:0]  short_active_reg;
    logic [COUNT_BITS-1:0]  sleep_len_reg;
    logic [SAMPLE_BITS-1:0] relay_on_code_reg;
    logic [SAMPLE_BITS-1:0] long_win_code_reg;
    logic [SAMPLE_BITS-1:0] short_win_code_reg;

    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            measure_interval_reg <= COUNT_BITS'(RST_MEASURE_INTERVAL);
            relay_hold_reg       <= COUNT_BITS'(RST_RELAY_HOLD);
            long_active_reg      <= COUNT_BITS'(RST_LONG_ACTIVE);
            short_active_reg     <= COUNT_BITS'(RST_SHORT_ACTIVE);
            sleep_len_reg        <= COUNT_BITS'(RST_SLEEP);
            relay_on_code_reg    <= SAMPLE_BITS'(RST_RELAY_ON_CODE);
            long_win_code_reg    <= SAMPLE_BITS'(RST_LONG_WIN_CODE);
            short_win_code_reg   <= SAMPLE_BITS'(RST_SHORT_WIN_CODE);
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MEASURE_INTERVAL: measure_interval_reg <= pwdata[COUNT_BITS-1:0];
                REG_RELAY_HOLD:       relay_hold_reg       <= pwdata[COUNT_BITS-1:0];
                REG_LONG_ACTIVE:      long_active_reg      <= pwdata[COUNT_BITS-1:0];
                REG_SHORT_ACTIVE:     short_active_reg     <= pwdata[COUNT_BITS-1:0];
                REG_SLEEP:            sleep_len_reg        <= pwdata[COUNT_BITS-1:0];
                REG_RELAY_ON_CODE:    relay_on_code_reg    <= pwdata[SAMPLE_BITS-1:0];
                REG_LONG_WIN_CODE:    long_win_code_reg    <= pwdata[SAMPLE_BITS-1:0];
                REG_SHORT_WIN_CODE:   short_win_code_reg   <= pwdata[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MEASURE_INTERVAL: prdata = APB_DATA_BITS'(measure_interval_reg);
            REG_RELAY_HOLD:       prdata = APB_DATA_BITS'(relay_hold_reg);
            REG_LONG_ACTIVE:      prdata = APB_DATA_BITS'(long_active_reg);
            REG_SHORT_ACTIVE:     prdata = APB_DATA_BITS'(short_active_reg);
            REG_SLEEP:            prdata = APB_DATA_BITS'(sleep_len_reg);
            REG_RELAY_ON_CODE:    prdata = APB_DATA_BITS'(relay_on_code_reg);
            REG_LONG_WIN_CODE:    prdata = APB_DATA_BITS'(long_win_code_reg);
            REG_SHORT_WIN_CODE:   prdata = APB_DATA_BITS'(short_win_code_reg);
            default:              prdata = '0;
        endcase
    end

    assign measure_interval = measure_interval_reg;
    assign relay_hold       = relay_hold_reg;
    assign long_active      = long_active_reg;
    assign short_active     = short_active_reg;
    assign sleep_len        = sleep_len_reg;
    assign relay_on_code    = relay_on_code_reg;
    assign long_win_code    = long_win_code_reg;
    assign short_win_code   = short_win_code_reg;

endmodule

`default_nettype wire

// File: rtl/core/srst_step.sv
// Per-tick state update of the solar relay sleep timer: timer state registers
// and the logic that advances them by one tick. Depends on srst_pkg.
`default_nettype none

module srst_step
    import srst_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step_en,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic                   button,
    input  wire logic [COUNT_BITS-1:0]  measure_interval,
    input  wire logic [COUNT_BITS-1:0]  relay_hold,
    input  wire logic [COUNT_BITS-1:0]  long_active,
    input  wire logic [COUNT_BITS-1:0]  short_active,
    input  wire logic [COUNT_BITS-1:0]  sleep_len,
    input  wire logic [SAMPLE_BITS-1:0] relay_on_code,
    input  wire logic [SAMPLE_BITS-1:0] long_win_code,
    input  wire logic [SAMPLE_BITS-1:0] short_win_code,
    output logic                        res_relay,
    output logic                        res_awake,
    output logic      [SAMPLE_BITS-1:0] res_sample,
    output logic                        res_taken,
    output logic      [COUNT_BITS-1:0]  res_left
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic                   asleep_reg,         asleep_next;
    logic                   relay_reg,          relay_next;
    logic [SAMPLE_BITS-1:0] last_sample_reg,    last_sample_next;
    logic [COUNT_BITS-1:0]  since_sample_reg,   since_sample_next;
    logic [COUNT_BITS-1:0]  relay_elapsed_reg,  relay_elapsed_next;
    logic [COUNT_BITS-1:0]  active_elapsed_reg, active_elapsed_next;
    logic [COUNT_BITS-1:0]  sleep_elapsed_reg,  sleep_elapsed_next;

    logic [COUNT_BITS-1:0] since_inc, active_inc, relay_inc, sleep_inc;
    logic [COUNT_BITS-1:0] window;
    logic                  take;
    logic                  go_sleep;

    // Saturating increments of every counter.
    assign since_inc  = (since_sample_reg   == CNT_MAX) ? CNT_MAX : since_sample_reg   + 1'b1;
    assign active_inc = (active_elapsed_reg == CNT_MAX) ? CNT_MAX : active_elapsed_reg + 1'b1;
    assign relay_inc  = (relay_elapsed_reg  == CNT_MAX) ? CNT_MAX : relay_elapsed_reg  + 1'b1;
    assign sleep_inc  = (sleep_elapsed_reg  == CNT_MAX) ? CNT_MAX : sleep_elapsed_reg  + 1'b1;

    always_comb
    begin
        asleep_next         = asleep_reg;
        relay_next          = relay_reg;
        last_sample_next    = last_sample_reg;
        since_sample_next   = since_sample_reg;
        relay_elapsed_next  = relay_elapsed_reg;
        active_elapsed_next = active_elapsed_reg;
        sleep_elapsed_next  = sleep_elapsed_reg;
        take                = 1'b0;
        go_sleep            = 1'b0;

        if (asleep_reg)
        begin
            sleep_elapsed_next = sleep_inc;
            if (button || (sleep_inc >= sleep_len))
            begin
                asleep_next         = 1'b0;
                since_sample_next   = '0;
                active_elapsed_next = '0;
            end
        end
        else
        begin
            since_sample_next   = since_inc;
            active_elapsed_next = active_inc;
            if (relay_reg)
            begin
                relay_elapsed_next = relay_inc;
            end

            // Sample check, then relay switch-on from the fresh sample.
            if (since_inc >= measure_interval)
            begin
                take              = 1'b1;
                last_sample_next  = sample;
                since_sample_next = '0;
                if ((sample > relay_on_code) && !relay_reg)
                begin
                    relay_next         = 1'b1;
                    relay_elapsed_next = '0;
                end
            end

            if (relay_next && (relay_elapsed_next >= relay_hold))
            begin
                relay_next = 1'b0;
            end

            // The middle band between the two window codes never sleeps.
            go_sleep = ((active_inc >= long_active)  && (last_sample_next > long_win_code)) ||
                       ((active_inc >= short_active) && (last_sample_next < short_win_code));

            if (go_sleep)
            begin
                asleep_next        = 1'b1;
                relay_next         = 1'b0;
                sleep_elapsed_next = '0;
            end
            else if (button)
            begin
                since_sample_next   = '0;
                active_elapsed_next = '0;
            end
        end
    end

    // Result of this tick, taken from the updated state.
    assign window     = (last_sample_next < short_win_code) ? short_active : long_active;
    assign res_relay  = relay_next;
    assign res_awake  = !asleep_next;
    assign res_sample = last_sample_next;
    assign res_taken  = take;
    assign res_left   = (!asleep_next && (window > active_elapsed_next))
                        ? window - active_elapsed_next : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asleep_reg         <= 1'b0;
            relay_reg          <= 1'b0;
            last_sample_reg    <= '0;
            since_sample_reg   <= '0;
            relay_elapsed_reg  <= '0;
            active_elapsed_reg <= '0;
            sleep_elapsed_reg  <= '0;
        end
        else if (step_en)
        begin
            asleep_reg         <= asleep_next;
            relay_reg          <= relay_next;
            last_sample_reg    <= last_sample_next;
            since_sample_reg   <= since_sample_next;
            relay_elapsed_reg  <= relay_elapsed_next;
            active_elapsed_reg <= active_elapsed_next;
            sleep_elapsed_reg  <= sleep_elapsed_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/solar_relay_sleep_timer_top.sv
// Top level of the solar relay sleep timer: input word register, tick step
// logic and result register. Depends on srst_pkg, srst_cfg and srst_step.
`default_nettype none

// Usage
// The block is fed one input word per millisecond tick on the in channel
// (adc_sample, button_pressed) and returns exactly one result word per input
// word on the out channel (relay_on, awake, stored_sample, sample_taken,
// ticks_left). Both channels use a valid/ready handshake.
// An accepted word is held in the input register; when it moves on, the tick
// logic updates the timer state and writes the result register, setting
// out_valid. Throughput is one word per clock cycle while out_ready is high:
// the tick logic is a handful of saturating increments and compares between
// the input register and the result register, and the input register refills
// in the same cycle that it drains.
// When the receiver stalls (out_ready low with a result waiting), the result
// register holds, the input register keeps one more word, and in_ready drops
// only once both are full; nothing is lost or repeated.
// Reset (rst_n low, asynchronous) empties both registers, puts the block in
// the awake state with the relay off, clears the stored sample and all tick
// counters, and loads the configuration registers with their defaults.
// Configuration registers are written over the APB-style port at byte
// address 4*i and should only be changed while no word is in flight.
module solar_relay_sleep_timer_top
    import srst_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // Configuration port.
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    // Input channel.
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [SAMPLE_BITS-1:0]   adc_sample,
    input  wire logic                     button_pressed,
    // Output channel.
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          relay_on,
    output logic                          awake,
    output logic      [SAMPLE_BITS-1:0]   stored_sample,
    output logic                          sample_taken,
    output logic      [COUNT_BITS-1:0]    ticks_left
);

    logic [COUNT_BITS-1:0]  measure_interval;
    logic [COUNT_BITS-1:0]  relay_hold;
    logic [COUNT_BITS-1:0]  long_active;
    logic [COUNT_BITS-1:0]  short_active;
    logic [COUNT_BITS-1:0]  sleep_len;
    logic [SAMPLE_BITS-1:0] relay_on_code;
    logic [SAMPLE_BITS-1:0] long_win_code;
    logic [SAMPLE_BITS-1:0] short_win_code;

    // Input word register.
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic                   in_button_reg;

    // Result word register.
    logic                   out_valid_reg;
    logic                   out_relay_reg;
    logic                   out_awake_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic                   out_taken_reg;
    logic [COUNT_BITS-1:0]  out_left_reg;

    logic                   res_relay;
    logic                   res_awake;
    logic [SAMPLE_BITS-1:0] res_sample;
    logic                   res_taken;
    logic [COUNT_BITS-1:0]  res_left;

    logic advance;
    logic in_fire;

    // The held word moves on when the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    srst_cfg #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .measure_interval (measure_interval),
        .relay_hold       (relay_hold),
        .long_active      (long_active),
        .short_active     (short_active),
        .sleep_len        (sleep_len),
        .relay_on_code    (relay_on_code),
        .long_win_code    (long_win_code),
        .short_win_code   (short_win_code)
    );

    srst_step #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_step (
        .clk              (clk),
        .rst_n            (rst_n),
        .step_en          (advance),
        .sample           (in_sample_reg),
        .button           (in_button_reg),
        .measure_interval (measure_interval),
        .relay_hold       (relay_hold),
        .long_active      (long_active),
        .short_active     (short_active),
        .sleep_len        (sleep_len),
        .relay_on_code    (relay_on_code),
        .long_win_code    (long_win_code),
        .short_win_code   (short_win_code),
        .res_relay        (res_relay),
        .res_awake        (res_awake),
        .res_sample       (res_sample),
        .res_taken        (res_taken),
        .res_left         (res_left)
    );

    // Control bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_sample_reg <= adc_sample;
            in_button_reg <= button_pressed;
        end
        if (advance)
        begin
            out_relay_reg  <= res_relay;
            out_awake_reg  <= res_awake;
            out_sample_reg <= res_sample;
            out_taken_reg  <= res_taken;
            out_left_reg   <= res_left;
        end
    end

    assign out_valid     = out_valid_reg;
    assign relay_on      = out_relay_reg;
    assign awake         = out_awake_reg;
    assign stored_sample = out_sample_reg;
    assign sample_taken  = out_taken_reg;
    assign ticks_left    = out_left_reg;

endmodule

`default_nettype wire
